// ===== rtl/mfw_pkg.sv =====
// Shared constants, types and helpers for the streaming window median filter.
`default_nettype none

package mfw_pkg;

    // Geometry
    localparam int WINDOW     = 3;
    localparam int MAX_WIDTH  = 4096;
    localparam int PIXEL_BITS = 8;

    localparam int HALF_LO  = (WINDOW - 1) / 2;
    localparam int HALF_HI  = WINDOW - 1 - HALF_LO;
    localparam int TAPS     = WINDOW * WINDOW;
    localparam int MID_RANK = TAPS / 2;

    // Widths
    localparam int CFG_BITS     = 13;
    localparam int COL_BITS     = $clog2(MAX_WIDTH);
    localparam int ROW_BITS     = CFG_BITS;
    localparam int LAG_BITS     = $clog2(HALF_HI * MAX_WIDTH + HALF_HI + 1);
    localparam int RANK_BITS    = $clog2(TAPS + 1);
    localparam int CFG_IDX_BITS = 1;

    // Register map
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = CFG_IDX_BITS'(1);

    // Reset geometry, held as last column / last row
    localparam int RST_FRAME_WIDTH  = 640;
    localparam int RST_FRAME_HEIGHT = 480;
    localparam int RST_WIDTH_LAST   =
        (RST_FRAME_WIDTH > MAX_WIDTH ? MAX_WIDTH : RST_FRAME_WIDTH) - 1;
    localparam int RST_HEIGHT_LAST  = RST_FRAME_HEIGHT - 1;

    typedef logic [PIXEL_BITS-1:0] pix_t;
    typedef pix_t [WINDOW-1:0]     column_t;     // index 0 is the top row
    typedef pix_t [WINDOW-2:0]     line_word_t;  // slot s holds row R-1-s
    typedef pix_t [TAPS-1:0]       window_t;     // row-major window

    typedef struct packed {
        pix_t pixel;
        logic drain;
    } in_beat_t;

    typedef struct packed {
        pix_t median_pixel;
        logic last_of_frame;
    } out_beat_t;

    // Per-cell validity of its column inside the current window
    typedef struct packed {
        logic              col_ok;
        logic [WINDOW-1:0] row_ok;
    } cell_mask_t;

    function automatic logic [RANK_BITS-1:0] popcount(input logic [TAPS-1:0] bits);
        logic [RANK_BITS-1:0] acc;
        acc = '0;
        for (int k = 0; k < TAPS; k++) begin
            acc = acc + RANK_BITS'(bits[k]);
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mfw_line_store.sv =====
// Line store: one word per column holding the previous WINDOW-1 rows.
`default_nettype none

module mfw_line_store (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [mfw_pkg::COL_BITS-1:0]  rd_addr,
    input  logic                          wr_en,
    input  logic [mfw_pkg::COL_BITS-1:0]  wr_addr,
    input  mfw_pkg::line_word_t           wr_data,
    output mfw_pkg::line_word_t           rd_data
);

    mfw_pkg::line_word_t mem [mfw_pkg::MAX_WIDTH];
    mfw_pkg::line_word_t mem_rd_reg;
    mfw_pkg::line_word_t byp_data_reg;
    logic                byp_reg;

    // Memory port: write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            mem_rd_reg <= mem[rd_addr];
        end
    end

    // Forward a write that lands on the column being read in the same cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_reg <= 1'b0;
        end else if (rd_en) begin
            byp_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            byp_data_reg <= wr_data;
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : mem_rd_reg;

endmodule

`default_nettype wire

// ===== rtl/mfw_col_cell.sv =====
// Window column cell: holds one column, passes it to its neighbour on each shift.
`default_nettype none

module mfw_col_cell (
    input  logic                aclk,
    input  logic                shift_en,
    input  mfw_pkg::column_t    col_in,
    input  mfw_pkg::cell_mask_t mask,
    output mfw_pkg::column_t    col_o,
    output mfw_pkg::column_t    col_masked_o
);

    mfw_pkg::column_t col_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            col_reg <= col_in;
        end
    end

    // Pixels outside the frame read as zero
    always_comb begin
        for (int i = 0; i < mfw_pkg::WINDOW; i++) begin
            col_masked_o[i] = (mask.col_ok && mask.row_ok[i]) ? col_reg[i] : '0;
        end
    end

    assign col_o = col_reg;

endmodule

`default_nettype wire

// ===== rtl/mfw_rank_median.sv =====
// Rank-based median pick: compare matrix, rank match, one-hot select, output register.
`default_nettype none

module mfw_rank_median (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  mfw_pkg::window_t   in_win,
    input  logic               in_last,
    output logic               m_valid,
    input  logic               m_ready,
    output mfw_pkg::out_beat_t m_data
);

    typedef logic [mfw_pkg::TAPS-1:0] lt_row_t;

    // Compare stage
    logic                          vc_reg;
    mfw_pkg::window_t              winc_reg;
    logic                          lastc_reg;
    lt_row_t [mfw_pkg::TAPS-1:0]   lt_reg;
    lt_row_t [mfw_pkg::TAPS-1:0]   lt_next;

    // Select stage
    logic                          vs_reg;
    mfw_pkg::window_t              wins_reg;
    logic                          lasts_reg;
    logic [mfw_pkg::TAPS-1:0]      sel_reg;
    logic [mfw_pkg::TAPS-1:0]      sel_next;

    // Output register
    logic                          vo_reg;
    mfw_pkg::out_beat_t            out_reg;
    mfw_pkg::out_beat_t            out_next;

    logic rdy_s;
    logic rdy_o;

    assign rdy_o    = !vo_reg || m_ready;
    assign rdy_s    = !vs_reg || rdy_o;
    assign in_ready = !vc_reg || rdy_s;

    // Element j ranks below element i if smaller, or equal and earlier
    always_comb begin
        for (int i = 0; i < mfw_pkg::TAPS; i++) begin
            for (int j = 0; j < mfw_pkg::TAPS; j++) begin
                lt_next[i][j] = (in_win[j] < in_win[i]) ||
                                ((in_win[j] == in_win[i]) && (j < i));
            end
        end
    end

    // Ranks form a permutation, so exactly one element sits at the middle
    always_comb begin
        for (int i = 0; i < mfw_pkg::TAPS; i++) begin
            sel_next[i] = mfw_pkg::popcount(lt_reg[i]) ==
                          mfw_pkg::RANK_BITS'(mfw_pkg::MID_RANK);
        end
    end

    always_comb begin
        out_next = '0;
        for (int i = 0; i < mfw_pkg::TAPS; i++) begin
            out_next.median_pixel = out_next.median_pixel |
                                    (sel_reg[i] ? wins_reg[i] : '0);
        end
        out_next.last_of_frame = lasts_reg;
    end

    // Stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
            vs_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                vc_reg <= in_valid;
            end
            if (rdy_s) begin
                vs_reg <= vc_reg;
            end
            if (rdy_o) begin
                vo_reg <= vs_reg;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            winc_reg  <= in_win;
            lastc_reg <= in_last;
            lt_reg    <= lt_next;
        end
        if (rdy_s && vc_reg) begin
            wins_reg  <= winc_reg;
            lasts_reg <= lastc_reg;
            sel_reg   <= sel_next;
        end
        if (rdy_o && vs_reg) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = vo_reg;
    assign m_data  = out_reg;

`ifndef NO_ASSERTIONS
    // The middle rank is always held by exactly one window element
    a_sel_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        vs_reg |-> $onehot(sel_reg))
        else $error("median select is not one-hot");
`endif

endmodule

`default_nettype wire

// ===== rtl/median_filter_window.sv =====
// Streaming WINDOW x WINDOW median filter over a raster pixel stream.
// m_valid rises once a completing beat passes stages 1 and 2, compare, select and output.
// One beat per cycle unless stalled; output lags input by HALF_HI rows plus HALF_HI pixels.
// The line store takes one read and one write per beat, one column word wide.
// Reset: counters clear, geometry returns to 640 x 480; line store contents are not cleared,
// rows and columns outside the frame are masked to zero in the window.
`default_nettype none

module median_filter_window (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  mfw_pkg::in_beat_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output mfw_pkg::out_beat_t                m_data,
    input  logic                              cfg_wr_en,
    input  logic [mfw_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [mfw_pkg::CFG_BITS-1:0]      cfg_wdata
);

    localparam int W  = mfw_pkg::WINDOW;
    localparam int CB = mfw_pkg::COL_BITS;
    localparam int RB = mfw_pkg::ROW_BITS;
    localparam int LB = mfw_pkg::LAG_BITS;

    // Geometry and position counters
    logic [CB-1:0] wlast_reg, wlast_next;
    logic [RB-1:0] hlast_reg, hlast_next;
    logic [CB-1:0] col_reg,   col_next;
    logic [LB-1:0] pcnt_reg,  pcnt_next;
    logic          active_reg, active_next;
    logic [CB-1:0] qc_reg,    qc_next;
    logic [RB-1:0] qr_reg,    qr_next;

    logic [LB-1:0] lag;
    logic          out_now;
    logic          last_now;
    logic [W-1:0]  colok_next;
    logic [W-1:0]  rowok_next;

    // Stage 1: line store read done, column being formed
    logic                v1_reg;
    logic                o1_reg;
    logic                last1_reg;
    mfw_pkg::pix_t       pix1_reg;
    logic [CB-1:0]       col1_reg;
    logic [W-1:0]        colok1_reg;
    logic [W-1:0]        rowok1_reg;

    // Stage 2: masked window
    logic                v2_reg;
    mfw_pkg::window_t    win2_reg;
    mfw_pkg::window_t    win2_next;
    logic                last2_reg;

    logic                s_fire;
    logic                go1;
    logic                rdy2;
    logic                rank_ready;

    mfw_pkg::line_word_t line_rd;
    mfw_pkg::line_word_t line_wr;
    mfw_pkg::column_t    new_col;
    mfw_pkg::column_t    new_masked;
    mfw_pkg::column_t    cell_col [W-1];
    mfw_pkg::column_t    cell_win [W-1];

    // Handshake through the front stages
    assign rdy2    = !v2_reg || rank_ready;
    assign go1     = v1_reg && (!o1_reg || rdy2);
    assign s_ready = !v1_reg || go1;
    assign s_fire  = s_valid && s_ready;

    // First result appears HALF_HI rows plus HALF_HI pixels into the frame
    assign lag = LB'(mfw_pkg::HALF_HI) * LB'({1'b0, wlast_reg} + 1'b1) +
                 LB'(mfw_pkg::HALF_HI);

    assign out_now  = active_reg || (pcnt_reg == lag);
    assign last_now = out_now && (qc_reg == wlast_reg) && (qr_reg == hlast_reg);

    // Window masks for the output position
    always_comb begin : p_masks
        logic [CB:0] cpos;
        logic [CB:0] chi;
        logic [RB:0] rpos;
        logic [RB:0] rhi;
        chi = {1'b0, wlast_reg} + (CB + 1)'(mfw_pkg::HALF_LO);
        rhi = {1'b0, hlast_reg} + (RB + 1)'(mfw_pkg::HALF_LO);
        for (int j = 0; j < W; j++) begin
            cpos          = {1'b0, qc_reg} + (CB + 1)'(j);
            colok_next[j] = (cpos >= (CB + 1)'(mfw_pkg::HALF_LO)) && (cpos <= chi);
            rpos          = {1'b0, qr_reg} + (RB + 1)'(j);
            rowok_next[j] = (rpos >= (RB + 1)'(mfw_pkg::HALF_LO)) && (rpos <= rhi);
        end
    end

    // Counter and configuration next state
    always_comb begin
        wlast_next  = wlast_reg;
        hlast_next  = hlast_reg;
        col_next    = col_reg;
        pcnt_next   = pcnt_reg;
        active_next = active_reg;
        qc_next     = qc_reg;
        qr_next     = qr_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                mfw_pkg::REG_FRAME_WIDTH: begin
                    if (cfg_wdata == '0) begin
                        wlast_next = '0;
                    end else if (int'(cfg_wdata) > mfw_pkg::MAX_WIDTH) begin
                        wlast_next = CB'(mfw_pkg::MAX_WIDTH - 1);
                    end else begin
                        wlast_next = CB'(cfg_wdata - 1'b1);
                    end
                end
                mfw_pkg::REG_FRAME_HEIGHT: begin
                    hlast_next = (cfg_wdata == '0) ? '0 : RB'(cfg_wdata - 1'b1);
                end
                default: begin
                end
            endcase
            col_next    = '0;
            pcnt_next   = '0;
            active_next = 1'b0;
            qc_next     = '0;
            qr_next     = '0;
        end else if (s_fire) begin
            if (last_now) begin
                col_next    = '0;
                pcnt_next   = '0;
                active_next = 1'b0;
                qc_next     = '0;
                qr_next     = '0;
            end else begin
                col_next = (col_reg == wlast_reg) ? '0 : col_reg + 1'b1;
                if (out_now) begin
                    active_next = 1'b1;
                    if (qc_reg == wlast_reg) begin
                        qc_next = '0;
                        qr_next = qr_reg + 1'b1;
                    end else begin
                        qc_next = qc_reg + 1'b1;
                    end
                end else begin
                    pcnt_next = pcnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlast_reg  <= CB'(mfw_pkg::RST_WIDTH_LAST);
            hlast_reg  <= RB'(mfw_pkg::RST_HEIGHT_LAST);
            col_reg    <= '0;
            pcnt_reg   <= '0;
            active_reg <= 1'b0;
            qc_reg     <= '0;
            qr_reg     <= '0;
        end else begin
            wlast_reg  <= wlast_next;
            hlast_reg  <= hlast_next;
            col_reg    <= col_next;
            pcnt_reg   <= pcnt_next;
            active_reg <= active_next;
            qc_reg     <= qc_next;
            qr_reg     <= qr_next;
        end
    end

    // Front stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= go1 && o1_reg;
            end
        end
    end

    // Stage 1 payload; a drain beat stores zero
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            o1_reg     <= out_now;
            last1_reg  <= last_now;
            pix1_reg   <= s_data.drain ? '0 : s_data.pixel;
            col1_reg   <= col_reg;
            colok1_reg <= colok_next;
            rowok1_reg <= rowok_next;
        end
    end

    mfw_line_store u_line_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_fire),
        .rd_addr (col_reg),
        .wr_en   (go1),
        .wr_addr (col1_reg),
        .wr_data (line_wr),
        .rd_data (line_rd)
    );

    // New column: stored rows on top, current pixel at the bottom
    always_comb begin
        for (int i = 0; i < W - 1; i++) begin
            new_col[i] = line_rd[W - 2 - i];
        end
        new_col[W - 1] = pix1_reg;
        for (int i = 0; i < W; i++) begin
            new_masked[i] = (colok1_reg[W - 1] && rowok1_reg[i]) ? new_col[i] : '0;
        end
    end

    // Push the current pixel into the column word, oldest row drops out
    always_comb begin
        line_wr[0] = pix1_reg;
        for (int s = 1; s < W - 1; s++) begin
            line_wr[s] = line_rd[s - 1];
        end
    end

    // Chain of column cells, oldest column at index 0
    genvar gj;
    generate
        for (gj = 0; gj < W - 1; gj++) begin : g_cell
            mfw_pkg::column_t    feed;
            mfw_pkg::cell_mask_t cmask;
            if (gj == W - 2) begin : g_head
                assign feed = new_col;
            end else begin : g_link
                assign feed = cell_col[gj + 1];
            end
            assign cmask = '{col_ok: colok1_reg[gj], row_ok: rowok1_reg};
            mfw_col_cell u_cell (
                .aclk         (aclk),
                .shift_en     (go1),
                .col_in       (feed),
                .mask         (cmask),
                .col_o        (cell_col[gj]),
                .col_masked_o (cell_win[gj])
            );
        end
    endgenerate

    // Window = stored columns plus the incoming one
    always_comb begin
        for (int i = 0; i < W; i++) begin
            for (int j = 0; j < W - 1; j++) begin
                win2_next[i * W + j] = cell_win[j][i];
            end
            win2_next[i * W + W - 1] = new_masked[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && go1 && o1_reg) begin
            win2_reg  <= win2_next;
            last2_reg <= last1_reg;
        end
    end

    mfw_rank_median u_rank (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (v2_reg),
        .in_ready (rank_ready),
        .in_win   (win2_reg),
        .in_last  (last2_reg),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

`ifndef NO_ASSERTIONS
    // Once results flow, the lead counter sits exactly at the lag
    a_lead_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (pcnt_reg == lag))
        else $error("lead counter drifted while active");

    // Positions never run past the frame geometry
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_reg <= wlast_reg) && (qc_reg <= wlast_reg) && (qr_reg <= hlast_reg))
        else $error("position counter out of frame");

    // The frame's last beat restarts all counters
    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && last_now) |=> ((col_reg == '0) && !active_reg && (pcnt_reg == '0) &&
                                  (qc_reg == '0) && (qr_reg == '0)))
        else $error("counters not cleared after frame end");

    // Input stalls only behind a result-carrying beat blocked at stage 2
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && o1_reg && v2_reg && !rank_ready))
        else $error("input stalled without a blocked result");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the streaming window median filter.
`timescale 1ns / 1ps

module tb;

    localparam int     HOLD_CYCLES   = 400;
    localparam int     DRAIN_LIMIT   = 20000;
    localparam int     SETTLE_CYCLES = 16;
    localparam longint RUN_LIMIT_NS  = 2_000_000;

    // Predicts the filtered stream and checks each result beat in order
    class median_scoreboard;
        logic [mfw_pkg::CFG_BITS-1:0] width_reg;
        logic [mfw_pkg::CFG_BITS-1:0] height_reg;
        int                           col_pos;
        int                           row_pos;
        mfw_pkg::pix_t                line_ring [mfw_pkg::WINDOW+1][mfw_pkg::MAX_WIDTH];
        mfw_pkg::out_beat_t           median_q [$];
        int                           mismatches;
        int                           results_seen;
        int                           inputs_seen;
        int                           frames_seen;

        function new();
            width_reg    = mfw_pkg::RST_FRAME_WIDTH;
            height_reg   = mfw_pkg::RST_FRAME_HEIGHT;
            col_pos      = 0;
            row_pos      = 0;
            mismatches   = 0;
            results_seen = 0;
            inputs_seen  = 0;
            frames_seen  = 0;
        endfunction

        // Geometry as the block sees it: zero acts as one, width clamps at the store size
        function int frame_cols();
            if (width_reg == 0) return 1;
            if (width_reg > mfw_pkg::MAX_WIDTH) return mfw_pkg::MAX_WIDTH;
            return int'(width_reg);
        endfunction

        function int frame_rows();
            return (height_reg == 0) ? 1 : int'(height_reg);
        endfunction

        function int pending();
            return median_q.size();
        endfunction

        // Any write restarts the frame
        function void write_register(logic [mfw_pkg::CFG_IDX_BITS-1:0] idx,
                                     logic [mfw_pkg::CFG_BITS-1:0] value);
            case (idx)
                mfw_pkg::REG_FRAME_WIDTH:  width_reg  = value;
                mfw_pkg::REG_FRAME_HEIGHT: height_reg = value;
                default: ;
            endcase
            col_pos = 0;
            row_pos = 0;
        endfunction

        task report_mismatch(string msg);
            if (mismatches < 40) $display("MISMATCH @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        // Store the beat, then work out the median centred HALF_HI rows and pixels back
        function void note_input(mfw_pkg::in_beat_t beat);
            int                 cols, rows, col, row, top, left, y, x, k;
            longint             pos, lag, centre;
            mfw_pkg::pix_t      taps [mfw_pkg::TAPS];
            mfw_pkg::pix_t      median;
            mfw_pkg::out_beat_t want;
            inputs_seen++;
            cols = frame_cols();
            rows = frame_rows();
            col  = (col_pos >= cols) ? cols - 1 : col_pos;
            row  = row_pos;
            if (row < rows)
                line_ring[row % (mfw_pkg::WINDOW+1)][col] = beat.drain ? '0 : beat.pixel;

            pos = longint'(row) * cols + col;
            lag = longint'(mfw_pkg::HALF_HI) * cols + mfw_pkg::HALF_HI;
            if (pos >= lag) begin
                centre = pos - lag;
                top    = int'(centre / cols) - mfw_pkg::HALF_LO;
                left   = int'(centre % cols) - mfw_pkg::HALF_LO;
                k      = 0;
                // outside the frame counts as zero
                for (int dy = 0; dy < mfw_pkg::WINDOW; dy++) begin
                    for (int dx = 0; dx < mfw_pkg::WINDOW; dx++) begin
                        y       = top + dy;
                        x       = left + dx;
                        taps[k] = '0;
                        if (y >= 0 && y < rows && x >= 0 && x < cols)
                            taps[k] = line_ring[y % (mfw_pkg::WINDOW+1)][x];
                        k++;
                    end
                end
                // smallest tap with more than MID_RANK taps at or below it
                median = '1;
                for (int i = 0; i < mfw_pkg::TAPS; i++) begin
                    int at_or_below;
                    at_or_below = 0;
                    for (int j = 0; j < mfw_pkg::TAPS; j++) begin
                        if (taps[j] <= taps[i]) at_or_below++;
                    end
                    if (at_or_below > mfw_pkg::MID_RANK && taps[i] <= median)
                        median = taps[i];
                end
                want.median_pixel  = median;
                want.last_of_frame = (centre + 1 == longint'(cols) * rows);
                median_q.insert(median_q.size(), want);
                if (want.last_of_frame) begin
                    col_pos = 0;
                    row_pos = 0;
                    return;
                end
            end

            col++;
            if (col >= cols) begin
                col = 0;
                row++;
            end
            col_pos = col;
            row_pos = row;
        endfunction

        task check_result(mfw_pkg::out_beat_t got);
            mfw_pkg::out_beat_t want;
            results_seen++;
            if (median_q.size() == 0) begin
                report_mismatch($sformatf("unexpected beat median=%0d last=%0b",
                                          got.median_pixel, got.last_of_frame));
                return;
            end
            want = median_q.pop_front();
            if (got.median_pixel !== want.median_pixel)
                report_mismatch($sformatf("median %0d, expected %0d",
                                          got.median_pixel, want.median_pixel));
            if (got.last_of_frame !== want.last_of_frame)
                report_mismatch($sformatf("last_of_frame %0b, expected %0b",
                                          got.last_of_frame, want.last_of_frame));
            if (want.last_of_frame) frames_seen++;
        endtask

        task flush_left_over();
            if (median_q.size() != 0)
                report_mismatch($sformatf("%0d result beats never arrived", median_q.size()));
            median_q.delete();
        endtask
    endclass

    logic                               aclk;
    logic                               aresetn;
    logic                               s_valid;
    logic                               s_ready;
    mfw_pkg::in_beat_t                  s_data;
    logic                               m_valid;
    logic                               m_ready;
    mfw_pkg::out_beat_t                 m_data;
    logic                               cfg_wr_en;
    logic [mfw_pkg::CFG_IDX_BITS-1:0]   cfg_index;
    logic [mfw_pkg::CFG_BITS-1:0]       cfg_wdata;

    median_scoreboard sb;
    int               send_idle_pct;
    int               stall_pct;
    bit               hold_req;
    int               items_sent;
    int               reg_writes;
    int               input_stalls;

    median_filter_window u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // Input back-pressure seen while offering a beat
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready === 1'b0) input_stalls++;
    end

    // Result side: check accepted beats, stall at random, long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid === 1'b1 && m_ready) sb.check_result(m_data);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Run limit
    initial begin
        #RUN_LIMIT_NS;
        $display("Test completed with failures");
        $finish;
    end

    task automatic write_register(input logic [mfw_pkg::CFG_IDX_BITS-1:0] idx,
                                  input logic [mfw_pkg::CFG_BITS-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_register(idx, value);
        reg_writes++;
    endtask

    // Offer one beat after a random gap and hold it until taken
    task automatic send_beat(input mfw_pkg::pix_t pixel, input logic drain);
        mfw_pkg::in_beat_t beat;
        beat.pixel = pixel;
        beat.drain = drain;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_input(beat);
        items_sent++;
    endtask

    // One frame of pixels plus the padding beats that flush it, optionally cut short
    task automatic stream_frame(input bit cut_short);
        int            pixels, total, stop_at;
        mfw_pkg::pix_t value;
        pixels  = sb.frame_cols() * sb.frame_rows();
        total   = pixels + mfw_pkg::HALF_HI * sb.frame_cols() + mfw_pkg::HALF_HI;
        stop_at = cut_short ? int'($urandom_range(0, total - 1)) : total;
        for (int n = 0; n < stop_at; n++) begin
            case ($urandom_range(7))
                0:       value = '0;
                1:       value = '1;
                2, 3:    value = mfw_pkg::pix_t'($urandom_range(120, 123));
                default: value = mfw_pkg::pix_t'($urandom);
            endcase
            send_beat(value, (n >= pixels) ? ($urandom_range(3) != 0)
                                           : ($urandom_range(15) == 0));
        end
    endtask

    // Let every expected beat arrive, then allow the pipeline to empty
    task automatic wait_drained();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (sb.pending() > 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        sb.flush_left_over();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int idle_send [4];
        int idle_recv [4];
        int mode;
        int budget;
        logic [mfw_pkg::CFG_BITS-1:0] cols_val;
        logic [mfw_pkg::CFG_BITS-1:0] rows_val;

        idle_send = '{0, 52, 0, 19};
        idle_recv = '{0, 0, 52, 19};
        sb = new();
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = 1'b0;
        items_sent    = 0;
        reg_writes    = 0;
        input_stalls  = 0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // 3x3 frame: saturated values, a drain inside the frame, a pixel among the padding
        send_idle_pct = 19;
        stall_pct     = 19;
        write_register(mfw_pkg::REG_FRAME_WIDTH, 13'd3);
        write_register(mfw_pkg::REG_FRAME_HEIGHT, 13'd3);
        send_beat(8'hFF, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hC8, 1'b1);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h11, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'h00, 1'b1);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b1);
        send_beat(8'hAA, 1'b1);
        wait_drained();

        // zero geometry acts as a 1x1 frame
        write_register(mfw_pkg::REG_FRAME_WIDTH, 13'd0);
        write_register(mfw_pkg::REG_FRAME_HEIGHT, 13'd0);
        send_beat(8'h5A, 1'b0);
        send_beat(8'hA5, 1'b0);
        send_beat(8'h00, 1'b1);
        wait_drained();

        // part of a 2x2 frame, abandoned by the next register write
        write_register(mfw_pkg::REG_FRAME_WIDTH, 13'd2);
        write_register(mfw_pkg::REG_FRAME_HEIGHT, 13'd2);
        send_beat(8'h81, 1'b0);
        send_beat(8'h7E, 1'b0);
        send_beat(8'h33, 1'b0);
        wait_drained();

        // random geometries under each idle mix; the first one with a long hold-off
        for (int phase = 0; phase < 8; phase++) begin
            mode          = phase % 4;
            send_idle_pct = idle_send[mode];
            stall_pct     = idle_recv[mode];
            case ($urandom_range(9))
                0:       cols_val = 13'd0;
                1:       cols_val = 13'd1;
                8:       cols_val = mfw_pkg::CFG_BITS'($urandom_range(13, 40));
                default: cols_val = mfw_pkg::CFG_BITS'($urandom_range(2, 12));
            endcase
            rows_val = ($urandom_range(7) == 0) ? 13'd0
                                                : mfw_pkg::CFG_BITS'($urandom_range(1, 6));
            write_register(mfw_pkg::REG_FRAME_WIDTH, cols_val);
            write_register(mfw_pkg::REG_FRAME_HEIGHT, rows_val);
            if (phase == 0) hold_req = 1'b1;
            budget = items_sent + 110;
            while (items_sent < budget) stream_frame($urandom_range(5) == 0);
            wait_drained();
        end

        // widest row, clamped to the store size: nothing is due within a short run
        send_idle_pct = 0;
        stall_pct     = 0;
        write_register(mfw_pkg::REG_FRAME_WIDTH, 13'h1FFF);
        write_register(mfw_pkg::REG_FRAME_HEIGHT, 13'd1);
        for (int n = 0; n < 40; n++) send_beat(mfw_pkg::pix_t'($urandom), 1'b0);
        wait_drained();

        // tallest column, one pixel wide, run part way
        write_register(mfw_pkg::REG_FRAME_WIDTH, 13'd1);
        write_register(mfw_pkg::REG_FRAME_HEIGHT, 13'h1FFF);
        for (int n = 0; n < 60; n++)
            send_beat(mfw_pkg::pix_t'($urandom), ($urandom_range(7) == 0));
        wait_drained();

        $display("Covered %0d input beats, %0d result beats over %0d whole frames,",
                 items_sent, sb.results_seen, sb.frames_seen);
        $display("%0d register writes, idle mixes on both sides, a %0d-cycle hold-off, %0d %s",
                 reg_writes, HOLD_CYCLES, input_stalls, "cycles of input back-pressure.");
        if (sb.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
